// File: design/mexp_pkg.sv
// mexp_pkg: shared types and constants of the modular exponentiation block
// no dependencies; used by mexp_ctrl, mexp_dp and modular_exponentiation_top

package mexp_pkg;

  localparam int OPERAND_BITS_DEFAULT = 31;
  localparam int BASE_BITS = 32;
  localparam int RESULT_BITS = 31;
  localparam int CFG_BITS = 31;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CNT_BITS = $clog2(BASE_BITS);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MODULUS,
    CFG_EXPONENT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_STEP,
    OP_SAVE_BASE,
    OP_LOAD_MUL,
    OP_LOAD_SQR,
    OP_MUL_STEP,
    OP_ACC_SQR,
    OP_SAVE_SQ,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_SAVE_BASE,
    S_BIT,
    S_MUL,
    S_ACC,
    S_SQR,
    S_SAVE_SQ,
    S_FIN
  } state_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_bit;
  } dp_status_t;

endpackage

// File: design/mexp_dp.sv
// mexp_dp: key registers, operand registers and the bit-serial multiply-reduce step
// depends on mexp_pkg; driven by commands from mexp_ctrl

module mexp_dp #(
  parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mexp_pkg::dp_op_t                     op,
  output mexp_pkg::dp_status_t                 status,
  input  logic [mexp_pkg::BASE_BITS-1:0]       base_value,
  input  logic                                 cfg_write,
  input  logic [mexp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mexp_pkg::CFG_BITS-1:0]        cfg_data,
  output logic                                 done,
  output logic [mexp_pkg::RESULT_BITS-1:0]     power_result,
  output logic                                 bad_modulus
);

  localparam int W = OPERAND_BITS;
  localparam int SB = mexp_pkg::BASE_BITS;
  localparam int ALIGN = SB - W;

  logic [W-1:0]  modulus_reg;
  logic [W-1:0]  exponent_reg;
  logic [W-1:0]  exp_sh;
  logic [W-1:0]  acc;
  logic [W-1:0]  sq;
  logic [W-1:0]  r;
  logic [W-1:0]  r_step;
  logic [SB-1:0] src;
  logic [W+1:0]  addend;
  logic [W+1:0]  t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;

  assign status.mod_zero = (modulus_reg == '0);
  assign status.exp_zero = (exponent_reg == '0);
  assign status.exp_bit  = exp_sh[0];

  // one step: r = (2r + addend) mod m, with 2r + addend below 3m
  always_comb begin
    if (!src[SB-1]) begin
      addend = '0;
    end else if (op == mexp_pkg::OP_RED_STEP) begin
      addend = (W+2)'(1);
    end else begin
      addend = (W+2)'(sq);
    end
    t  = (W+2)'({r, 1'b0}) + addend;
    m1 = (W+2)'(modulus_reg);
    m2 = (W+2)'({modulus_reg, 1'b0});
    if (t >= m2) begin
      r_step = W'(t - m2);
    end else if (t >= m1) begin
      r_step = W'(t - m1);
    end else begin
      r_step = W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_reg  <= W'(1);
      exponent_reg <= W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        mexp_pkg::CFG_MODULUS:  modulus_reg  <= W'(cfg_data);
        mexp_pkg::CFG_EXPONENT: exponent_reg <= W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (op == mexp_pkg::OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      mexp_pkg::OP_LOAD: begin
        src    <= base_value;
        r      <= '0;
        acc    <= W'(1);
        exp_sh <= exponent_reg;
      end
      mexp_pkg::OP_RED_STEP, mexp_pkg::OP_MUL_STEP: begin
        r   <= r_step;
        src <= {src[SB-2:0], 1'b0};
      end
      mexp_pkg::OP_SAVE_BASE: begin
        sq <= r;
      end
      mexp_pkg::OP_LOAD_MUL: begin
        src <= SB'(acc) << ALIGN;
        r   <= '0;
      end
      mexp_pkg::OP_LOAD_SQR: begin
        src <= SB'(sq) << ALIGN;
        r   <= '0;
      end
      mexp_pkg::OP_ACC_SQR: begin
        acc <= r;
        src <= SB'(sq) << ALIGN;
        r   <= '0;
      end
      mexp_pkg::OP_SAVE_SQ: begin
        sq     <= r;
        exp_sh <= exp_sh >> 1;
      end
      mexp_pkg::OP_FINISH: begin
        bad_modulus <= status.mod_zero;
        if (status.mod_zero) begin
          power_result <= '0;
        end else if (status.exp_zero) begin
          power_result <= mexp_pkg::RESULT_BITS'(1);
        end else begin
          power_result <= mexp_pkg::RESULT_BITS'(acc);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/mexp_ctrl.sv
// mexp_ctrl: sequencer for reduction, multiply and square passes
// depends on mexp_pkg; issues commands to mexp_dp

module mexp_ctrl #(
  parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  mexp_pkg::dp_status_t status,
  output mexp_pkg::dp_op_t     op
);

  localparam int CW = mexp_pkg::CNT_BITS;

  mexp_pkg::state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] bitcnt, bitcnt_next;

  assign busy = (state != mexp_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mexp_pkg::S_IDLE;
      cnt    <= '0;
      bitcnt <= '0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      bitcnt <= bitcnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    bitcnt_next = bitcnt;
    op          = mexp_pkg::OP_NONE;
    case (state)
      mexp_pkg::S_IDLE: begin
        if (start) begin
          op = mexp_pkg::OP_LOAD;
          cnt_next = CW'(mexp_pkg::BASE_BITS - 1);
          if (status.mod_zero || status.exp_zero) begin
            state_next = mexp_pkg::S_FIN;
          end else begin
            state_next = mexp_pkg::S_RED;
          end
        end
      end
      mexp_pkg::S_RED: begin
        op = mexp_pkg::OP_RED_STEP;
        if (cnt == '0) begin
          state_next = mexp_pkg::S_SAVE_BASE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      mexp_pkg::S_SAVE_BASE: begin
        op = mexp_pkg::OP_SAVE_BASE;
        bitcnt_next = CW'(OPERAND_BITS - 1);
        state_next = mexp_pkg::S_BIT;
      end
      mexp_pkg::S_BIT: begin
        cnt_next = CW'(OPERAND_BITS - 1);
        if (status.exp_bit) begin
          op = mexp_pkg::OP_LOAD_MUL;
          state_next = mexp_pkg::S_MUL;
        end else begin
          op = mexp_pkg::OP_LOAD_SQR;
          state_next = mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_MUL: begin
        op = mexp_pkg::OP_MUL_STEP;
        if (cnt == '0) begin
          state_next = mexp_pkg::S_ACC;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      mexp_pkg::S_ACC: begin
        op = mexp_pkg::OP_ACC_SQR;
        cnt_next = CW'(OPERAND_BITS - 1);
        state_next = mexp_pkg::S_SQR;
      end
      mexp_pkg::S_SQR: begin
        op = mexp_pkg::OP_MUL_STEP;
        if (cnt == '0) begin
          state_next = mexp_pkg::S_SAVE_SQ;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      mexp_pkg::S_SAVE_SQ: begin
        op = mexp_pkg::OP_SAVE_SQ;
        if (bitcnt == '0) begin
          state_next = mexp_pkg::S_FIN;
        end else begin
          bitcnt_next = bitcnt - 1'b1;
          state_next = mexp_pkg::S_BIT;
        end
      end
      mexp_pkg::S_FIN: begin
        op = mexp_pkg::OP_FINISH;
        state_next = mexp_pkg::S_IDLE;
      end
      default: begin
        state_next = mexp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: design/modular_exponentiation_top.sv
// modular_exponentiation_top: base ** exponent mod modulus, right-to-left square-and-multiply
// depends on mexp_pkg, mexp_ctrl and mexp_dp
//
//   channel   handshake           payload
//   input     start & !busy       base_value
//   result    done (one cycle)    power_result, bad_modulus
//   config    cfg_write           cfg_index, cfg_data
//
// the base is reduced first, then each exponent bit takes a square pass, or a
// multiply pass and a square pass when the bit is set, on the one shared
// bit-serial multiply-reduce step
// zero modulus or zero exponent: start goes straight to the finish state, no passes run
// done rises on the edge where busy falls; results cannot be stalled
// rst is synchronous and restores modulus 1 and exponent 1

module modular_exponentiation_top #(
  parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mexp_pkg::BASE_BITS-1:0]       base_value,
  output logic                                 done,
  output logic [mexp_pkg::RESULT_BITS-1:0]     power_result,
  output logic                                 bad_modulus,
  input  logic                                 cfg_write,
  input  logic [mexp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mexp_pkg::CFG_BITS-1:0]        cfg_data
);

  mexp_pkg::dp_op_t     op;
  mexp_pkg::dp_status_t status;

  mexp_ctrl #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .op     (op)
  );

  mexp_dp #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .base_value   (base_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .power_result (power_result),
    .bad_modulus  (bad_modulus)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not start work");

  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("work ended without a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && bad_modulus |-> power_result == '0)
    else $error("nonzero result with zero modulus");

endmodule

// File: sim/modular_exponentiation_top_tb.sv
// modular_exponentiation_top_tb: self-checking testbench of modular_exponentiation_top
// depends on mexp_pkg and the block; predicts base ** exponent mod modulus per transfer
// directed key corner cases first, then random key phases with bursty stimulus

module modular_exponentiation_top_tb;

  localparam int QUIET_LIMIT = 12000;
  localparam int TAIL_CYCLES = 40;
  localparam int TARGET_ITEMS = 290;
  localparam int BB = mexp_pkg::BASE_BITS;
  localparam int RB = mexp_pkg::RESULT_BITS;
  localparam int CB = mexp_pkg::CFG_BITS;
  localparam int IB = mexp_pkg::CFG_INDEX_BITS;

  typedef enum logic [1:0] {
    JOB_BASE,
    JOB_KEY,
    JOB_PAUSE
  } job_kind_t;

  typedef struct {
    job_kind_t          kind;
    logic [BB-1:0]      base;
    mexp_pkg::cfg_reg_t which;
    logic [CB-1:0]      value;
  } job_t;

  typedef struct packed {
    logic [RB-1:0] power;
    logic          bad;
  } power_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [BB-1:0] base_value = '0;
  logic          done;
  logic [RB-1:0] power_result;
  logic          bad_modulus;
  logic          cfg_write = 1'b0;
  logic [IB-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;

  job_t   job_q[$];
  power_t expected_powers[$];

  logic [CB-1:0] modulus_q;
  logic [CB-1:0] exponent_q;
  logic          base_taken = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int quiet_cycles = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_key_writes = 0;
  int n_zero_mod = 0;
  int n_zero_exp = 0;

  modular_exponentiation_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .base_value  (base_value),
    .done        (done),
    .power_result(power_result),
    .bad_modulus (bad_modulus),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic power_t predict_power(logic [BB-1:0] b);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m;
    power_t      r;
    m = 64'(modulus_q);
    r.bad = 1'b0;
    r.power = '0;
    if (modulus_q == '0) begin
      r.bad = 1'b1;
    end else if (exponent_q == '0) begin
      r.power = RB'(1);
    end else begin
      acc = 64'd1;
      sq = 64'(b) % m;
      for (int i = 0; i < CB; i++) begin
        if (exponent_q[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      r.power = acc[RB-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s, got %0h expected %0h (modulus %0h exponent %0h)",
             $time, what, got, want, modulus_q, exponent_q);
    n_errors++;
  endtask

  task automatic add_base(logic [BB-1:0] b);
    job_t j;
    j.kind = JOB_BASE;
    j.base = b;
    j.which = mexp_pkg::CFG_MODULUS;
    j.value = '0;
    job_q.push_back(j);
  endtask

  task automatic add_key(mexp_pkg::cfg_reg_t which, logic [CB-1:0] value);
    job_t j;
    j.kind = JOB_KEY;
    j.base = '0;
    j.which = which;
    j.value = value;
    job_q.push_back(j);
  endtask

  task automatic add_pause();
    job_t j;
    j.kind = JOB_PAUSE;
    j.base = '0;
    j.which = mexp_pkg::CFG_MODULUS;
    j.value = '0;
    job_q.push_back(j);
  endtask

  // driver: one item per start transfer, key writes only with the block idle
  always @(negedge clk) begin
    logic          go;
    logic          wr;
    logic [BB-1:0] b;
    logic [IB-1:0] idx;
    logic [CB-1:0] dat;
    int            pick;
    go = start;
    wr = 1'b0;
    b = base_value;
    idx = IB'($urandom);
    dat = CB'($urandom);
    if (start && base_taken) begin
      go = 1'b0;
      void'(job_q.pop_front());
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 5);
        pick = $urandom_range(0, 99);
        gap_left = (pick < 40) ? 0 :
                   (pick < 75) ? $urandom_range(1, 3) :
                   (pick < 95) ? $urandom_range(4, 40) : $urandom_range(41, 300);
      end
    end
    if (!rst && !go) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (job_q.size() > 0) begin
        case (job_q[0].kind)
          JOB_BASE: begin
            go = 1'b1;
            b = job_q[0].base;
          end
          JOB_KEY: begin
            if (expected_powers.size() == 0 && !busy) begin
              wr = 1'b1;
              idx = job_q[0].which;
              dat = job_q[0].value;
              void'(job_q.pop_front());
            end
          end
          JOB_PAUSE: begin
            if (expected_powers.size() == 0 && !busy) void'(job_q.pop_front());
          end
          default: ;
        endcase
      end
    end
    if (!go) b = $urandom;
    start <= go;
    base_value <= b;
    cfg_write <= wr;
    cfg_index <= idx;
    cfg_data <= dat;
  end

  // monitor: key tracking, prediction at each transfer, result checking, watchdog
  always @(posedge clk) begin
    power_t want;
    logic   moved;
    if (rst) begin
      modulus_q = CB'(1);
      exponent_q = CB'(1);
      base_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (done === 1'b1) begin
        moved = 1'b1;
        if (expected_powers.size() == 0) begin
          report_mismatch("result with none pending", power_result, 0);
        end else begin
          want = expected_powers.pop_front();
          if (power_result !== want.power || bad_modulus !== want.bad)
            report_mismatch("power_result,bad_modulus", {power_result, bad_modulus},
                            {want.power, want.bad});
          n_checked++;
        end
      end
      if (cfg_write) begin
        moved = 1'b1;
        n_key_writes++;
        case (mexp_pkg::cfg_reg_t'(cfg_index))
          mexp_pkg::CFG_MODULUS: modulus_q = cfg_data;
          mexp_pkg::CFG_EXPONENT: exponent_q = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        moved = 1'b1;
        expected_powers.push_back(predict_power(base_value));
        n_sent++;
        if (modulus_q == '0) n_zero_mod++;
        else if (exponent_q == '0) n_zero_exp++;
      end
      base_taken <= start && !busy;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [CB-1:0] key_mod;
    logic [CB-1:0] key_exp;
    int            n_items;
    int            phase_len;
    int            pick;

    // modulus one from reset, then zero exponent, zero modulus, widest key
    add_base(32'h0000_0000);
    add_base(32'h0000_0005);
    add_key(mexp_pkg::CFG_EXPONENT, '0);
    add_base(32'h0000_0007);
    add_key(mexp_pkg::CFG_MODULUS, '0);
    add_base(32'h0000_0000);
    add_base(32'hFFFF_FFFF);
    add_key(mexp_pkg::CFG_EXPONENT, 31'h7FFF_FFFF);
    add_base(32'h0000_0003);
    add_key(mexp_pkg::CFG_MODULUS, 31'h7FFF_FFFF);
    add_base(32'h0000_0000);
    add_base(32'h0000_0001);
    add_base(32'hFFFF_FFFF);
    add_base(32'h7FFF_FFFF);
    add_base(32'h7FFF_FFFE);
    add_base(32'h8000_0000);
    // textbook key pair, encrypt then decrypt
    add_key(mexp_pkg::CFG_MODULUS, 31'd3233);
    add_key(mexp_pkg::CFG_EXPONENT, 31'd17);
    add_base(32'd65);
    add_base(32'd3232);
    add_base(32'hFFFF_FFFF);
    add_key(mexp_pkg::CFG_EXPONENT, 31'd2753);
    add_base(32'd2790);
    add_pause();
    add_key(mexp_pkg::CFG_MODULUS, 31'd2);
    add_key(mexp_pkg::CFG_EXPONENT, 31'd1);
    add_base(32'hAAAA_AAAA);
    add_base(32'h5555_5555);
    n_items = 18;

    while (n_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) key_mod = CB'($urandom);
      else if (pick < 60) key_mod = CB'($urandom_range(2, 4095));
      else if (pick < 68) key_mod = '0;
      else if (pick < 76) key_mod = CB'(1);
      else if (pick < 84) key_mod = 31'h7FFF_FFFF;
      else key_mod = (CB'(1) << $urandom_range(1, 30)) | (CB'($urandom) & 31'hFF);
      pick = $urandom_range(0, 99);
      if (pick < 40) key_exp = CB'($urandom);
      else if (pick < 65) key_exp = CB'($urandom_range(1, 255));
      else if (pick < 75) key_exp = '0;
      else if (pick < 85) key_exp = 31'h7FFF_FFFF;
      else key_exp = CB'(1) << $urandom_range(0, 30);
      if ($urandom_range(0, 1) == 0) begin
        add_key(mexp_pkg::CFG_MODULUS, key_mod);
        add_key(mexp_pkg::CFG_EXPONENT, key_exp);
      end else begin
        add_key(mexp_pkg::CFG_EXPONENT, key_exp);
        add_key(mexp_pkg::CFG_MODULUS, key_mod);
      end
      phase_len = $urandom_range(6, 24);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < 5) add_pause();
        pick = $urandom_range(0, 99);
        if (pick < 70 || key_mod == '0) add_base($urandom);
        else if (pick < 85) add_base($urandom_range(0, 32'(key_mod) - 1));
        else if (pick < 88) add_base(32'(key_mod));
        else if (pick < 91) add_base(32'(key_mod) - 1);
        else if (pick < 94) add_base(32'(key_mod) + 32'(key_mod));
        else if (pick < 97) add_base(32'hFFFF_FFFF);
        else add_base($urandom_range(0, 1));
      end
      n_items += phase_len;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (job_q.size() == 0);
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_powers.size() != 0)
      report_mismatch("results never came", expected_powers.size(), 0);

    $display("sent %0d bases, checked %0d results across %0d key register writes",
             n_sent, n_checked, n_key_writes);
    $display("%0d bases under a zero modulus, %0d under a zero exponent",
             n_zero_mod, n_zero_exp);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/mexp_pkg.sv
design/mexp_dp.sv
design/mexp_ctrl.sv
design/modular_exponentiation_top.sv
sim/modular_exponentiation_top_tb.sv
